FILE: src/gpwa_pkg.sv
package gpwa_pkg;

	localparam int NUM_CHANNELS_DEF = 6;
	localparam int SAMPLE_BITS_DEF = 10;

	localparam int CHANNEL_BITS = 3;
	localparam int RAW_BITS = 10;
	localparam int ENABLED_BITS = 3;
	localparam int LIMIT_BITS = 11;
	localparam int VAC_LIMIT_BITS = 10;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 11;
	localparam int SEG_BITS = 8;

	// Scaled reading: hundredths of bar or mmHg, never above about 1140.
	localparam int READ_BITS = 11;

	// First pass: operand * coefficient, then drop the sample scale.
	localparam int COEF_BITS = 19;
	localparam int Q_BITS = 24;
	localparam logic [COEF_BITS-1:0] PRESS_COEF = 19'd12500;
	localparam logic [COEF_BITS-1:0] VAC_COEF = 19'd375031;

	// Second pass: exact floor division by 99 (pressure) or 9565 (vacuum).
	localparam int RECIP_BITS = 31;
	localparam int RECIP_SHIFT = 37;
	localparam logic [RECIP_BITS-1:0] PRESS_RECIP = 31'd1388272258;
	localparam logic [RECIP_BITS-1:0] VAC_RECIP = 31'd14368945;

	localparam logic [READ_BITS-1:0] PRESS_DISABLED = 11'd350;
	localparam logic [READ_BITS-1:0] VAC_DISABLED = 11'd500;

	// Channel codes and the count of channels the scheme knows about.
	localparam logic [CHANNEL_BITS-1:0] CH_P1 = 3'd0;
	localparam logic [CHANNEL_BITS-1:0] CH_P2 = 3'd1;
	localparam logic [CHANNEL_BITS-1:0] CH_P3 = 3'd2;
	localparam logic [CHANNEL_BITS-1:0] CH_P4 = 3'd3;
	localparam logic [CHANNEL_BITS-1:0] CH_P5 = 3'd4;
	localparam logic [CHANNEL_BITS-1:0] CH_VAC = 3'd5;
	localparam logic [CHANNEL_BITS:0] SCHEME_CHANNELS = 4'd6;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLED_CHANNELS = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_LIMIT = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_LIMIT = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_VACUUM_LIMIT = 2'd3;

	localparam logic [ENABLED_BITS-1:0] ENABLED_RESET = 3'd6;
	localparam logic [LIMIT_BITS-1:0] HIGH_LIMIT_RESET = 11'd600;
	localparam logic [LIMIT_BITS-1:0] LOW_LIMIT_RESET = 11'd250;
	localparam logic [VAC_LIMIT_BITS-1:0] VAC_LIMIT_RESET = 10'd400;

	typedef enum logic [1:0] {
		ST_NORMAL = 2'd0,
		ST_LOW = 2'd1,
		ST_HIGH = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_MUTE = 2'd1,
		KIND_IGNORE = 2'd2
	} kind_t;

	typedef struct packed {
		logic command;
		logic [CHANNEL_BITS-1:0] channel;
		logic [RAW_BITS-1:0] sample;
	} gpwa_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic fault;
		logic buzzer;
		logic [SEG_BITS-1:0] seg_ones;
		logic [SEG_BITS-1:0] seg_tens;
		logic [SEG_BITS-1:0] seg_hundreds;
	} gpwa_out_t;

	// Sideband that travels with a word through the scaling stages.
	typedef struct packed {
		kind_t kind;
		logic [CHANNEL_BITS-1:0] channel;
		logic vac;
		logic disabled;
	} gpwa_tag_t;

endpackage

FILE: src/gpwa_scale.sv
module gpwa_scale #(
	parameter int NUM_CHANNELS = gpwa_pkg::NUM_CHANNELS_DEF,
	parameter int SAMPLE_BITS = gpwa_pkg::SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  gpwa_pkg::gpwa_in_t item_s1,
	input  logic [gpwa_pkg::ENABLED_BITS-1:0] enabled_channels,
	input  logic load_s2,
	input  logic load_s3,
	output gpwa_pkg::gpwa_tag_t tag_s3,
	output logic [gpwa_pkg::READ_BITS-1:0] reading_s3
);

	localparam int OP_BITS = SAMPLE_BITS + 5;
	localparam int CB = gpwa_pkg::COEF_BITS;
	localparam int QB = gpwa_pkg::Q_BITS;
	localparam int MB = gpwa_pkg::RECIP_BITS;
	localparam int RB = gpwa_pkg::READ_BITS;
	localparam int KS = gpwa_pkg::RECIP_SHIFT;
	localparam logic [gpwa_pkg::CHANNEL_BITS:0] NUM_CH = (gpwa_pkg::CHANNEL_BITS + 1)'(NUM_CHANNELS);

	logic [SAMPLE_BITS-1:0] v;
	logic [OP_BITS-1:0] v_ext, ten_v, tf_v, full, vac_full, operand;
	logic [CB-1:0] coef;
	logic [OP_BITS+CB-1:0] prod1;
	logic [QB-1:0] q;
	logic ch_valid, ch_en;
	gpwa_pkg::gpwa_tag_t tag_s1, tag_s2;
	logic [QB-1:0] q_s2;
	logic [MB-1:0] recip;
	logic [QB+MB-1:0] prod2;
	logic [RB-1:0] r;

	// Channel decode and installed-channel check.
	always_comb begin
		ch_valid = ({1'b0, item_s1.channel} < gpwa_pkg::SCHEME_CHANNELS)
			&& ({1'b0, item_s1.channel} < NUM_CH);
		case (item_s1.channel)
			gpwa_pkg::CH_P1, gpwa_pkg::CH_P4: ch_en = 1'b1;
			gpwa_pkg::CH_VAC: ch_en = enabled_channels >= 3'd3;
			gpwa_pkg::CH_P2: ch_en = enabled_channels >= 3'd4;
			gpwa_pkg::CH_P3: ch_en = enabled_channels >= 3'd5;
			gpwa_pkg::CH_P5: ch_en = enabled_channels >= 3'd6;
			default: ch_en = 1'b0;
		endcase
		if (item_s1.command)
			tag_s1.kind = gpwa_pkg::KIND_MUTE;
		else if (ch_valid)
			tag_s1.kind = gpwa_pkg::KIND_SAMPLE;
		else
			tag_s1.kind = gpwa_pkg::KIND_IGNORE;
		tag_s1.channel = item_s1.channel;
		tag_s1.vac = item_s1.channel == gpwa_pkg::CH_VAC;
		tag_s1.disabled = !ch_en;
	end

	// First pass: offset and clamp at zero, then the coefficient multiply.
	always_comb begin
		v = SAMPLE_BITS'(item_s1.sample);
		v_ext = OP_BITS'(v);
		ten_v = (v_ext << 3) + (v_ext << 1);
		tf_v = (v_ext << 4) + (v_ext << 3) + v_ext;
		full = OP_BITS'(1) << SAMPLE_BITS;
		vac_full = (full << 4) + (full << 2) + (full << 1) + full;
		if (tag_s1.vac) begin
			operand = (tf_v < vac_full) ? vac_full - tf_v : '0;
			coef = gpwa_pkg::VAC_COEF;
		end else begin
			operand = (ten_v > full) ? ten_v - full : '0;
			coef = gpwa_pkg::PRESS_COEF;
		end
		prod1 = (OP_BITS + CB)'(operand) * (OP_BITS + CB)'(coef);
		q = QB'(prod1 >> SAMPLE_BITS);
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			q_s2 <= q;
			tag_s2 <= tag_s1;
		end
	end

	// Second pass: reciprocal multiply gives the exact floor quotient.
	always_comb begin
		recip = tag_s2.vac ? gpwa_pkg::VAC_RECIP : gpwa_pkg::PRESS_RECIP;
		prod2 = (QB + MB)'(q_s2) * (QB + MB)'(recip);
		r = prod2[KS+RB-1:KS];
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			tag_s3 <= tag_s2;
			if (tag_s2.disabled)
				reading_s3 <= tag_s2.vac ? gpwa_pkg::VAC_DISABLED : gpwa_pkg::PRESS_DISABLED;
			else
				reading_s3 <= r;
		end
	end

endmodule

FILE: src/gpwa_judge.sv
module gpwa_judge #(
	parameter int NUM_CHANNELS = gpwa_pkg::NUM_CHANNELS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  gpwa_pkg::gpwa_tag_t tag,
	input  logic [gpwa_pkg::READ_BITS-1:0] reading,
	input  logic [gpwa_pkg::LIMIT_BITS-1:0] high_limit,
	input  logic [gpwa_pkg::LIMIT_BITS-1:0] low_limit,
	input  logic [gpwa_pkg::VAC_LIMIT_BITS-1:0] vacuum_limit,
	output gpwa_pkg::gpwa_out_t result
);

	localparam int IDX_W = $clog2(NUM_CHANNELS);
	localparam int RB = gpwa_pkg::READ_BITS;

	gpwa_pkg::status_t chan_status_q [NUM_CHANNELS];
	gpwa_pkg::status_t status_n [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] chan_inside_q, chan_outside_q, inside_n, outside_n;
	logic fault_q, muted_q, fault_n, muted_n;
	logic [IDX_W-1:0] idx;
	logic [RB-1:0] lo_lim, hi_lim;
	logic lo, hi, in_window;
	logic [15:0] bcd;
	logic [3:0] d_ones, d_tens, d_hund;

	function automatic logic [15:0] to_bcd(input logic [RB-1:0] bin);
		logic [15:0] acc;
		acc = '0;
		for (int i = RB - 1; i >= 0; i--) begin
			for (int d = 0; d < 4; d++) begin
				if (acc[4*d +: 4] > 4'd4)
					acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
			end
			acc = {acc[14:0], bin[i]};
		end
		return acc;
	endfunction

	function automatic logic [gpwa_pkg::SEG_BITS-1:0] seg_code(input logic [3:0] digit);
		logic [gpwa_pkg::SEG_BITS-1:0] code;
		case (digit)
			4'd0: code = 8'hfc;
			4'd1: code = 8'h60;
			4'd2: code = 8'hda;
			4'd3: code = 8'hf2;
			4'd4: code = 8'h66;
			4'd5: code = 8'hb6;
			4'd6: code = 8'hbe;
			4'd7: code = 8'he0;
			4'd8: code = 8'hff;
			4'd9: code = 8'hf6;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

	// Window check and next state.
	always_comb begin
		idx = tag.channel[IDX_W-1:0];
		status_n = chan_status_q;
		inside_n = chan_inside_q;
		outside_n = chan_outside_q;
		fault_n = fault_q;
		muted_n = muted_q;
		if (tag.vac) begin
			lo_lim = RB'(vacuum_limit);
			hi_lim = '0;
			lo = reading < lo_lim;
			hi = 1'b0;
			in_window = reading > lo_lim;
		end else begin
			lo_lim = low_limit;
			hi_lim = high_limit;
			lo = reading < lo_lim;
			hi = reading > hi_lim;
			in_window = (reading > lo_lim) && (reading < hi_lim);
		end
		case (tag.kind)
			gpwa_pkg::KIND_MUTE: muted_n = 1'b1;
			gpwa_pkg::KIND_SAMPLE: begin
				// A reading right on a limit keeps the held status.
				if (lo)
					status_n[idx] = gpwa_pkg::ST_LOW;
				else if (hi)
					status_n[idx] = gpwa_pkg::ST_HIGH;
				else if (in_window)
					status_n[idx] = gpwa_pkg::ST_NORMAL;
				inside_n[idx] = in_window;
				outside_n[idx] = lo || hi;
				fault_n = fault_q || (|outside_n);
				if (&inside_n) begin
					fault_n = 1'b0;
					muted_n = 1'b0;
					for (int i = 0; i < NUM_CHANNELS; i++)
						status_n[i] = gpwa_pkg::ST_NORMAL;
				end
			end
			default: ;
		endcase
	end

	// Display digits: pressure shows tenths of bar, vacuum shows mmHg.
	always_comb begin
		bcd = to_bcd(reading);
		if (tag.vac) begin
			d_ones = bcd[3:0];
			d_tens = bcd[7:4];
			d_hund = (bcd[15:12] != 4'd0) ? 4'd9 : bcd[11:8];
		end else begin
			d_ones = bcd[7:4];
			d_tens = bcd[11:8];
			d_hund = (bcd[15:12] > 4'd9) ? 4'd9 : bcd[15:12];
		end
		result.fault = fault_n;
		result.buzzer = fault_n && !muted_n;
		if (tag.kind == gpwa_pkg::KIND_SAMPLE) begin
			result.status = status_n[idx];
			result.seg_ones = seg_code(d_ones);
			result.seg_tens = seg_code(d_tens);
			result.seg_hundreds = seg_code(d_hund);
		end else begin
			result.status = gpwa_pkg::ST_NORMAL;
			result.seg_ones = '0;
			result.seg_tens = '0;
			result.seg_hundreds = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++)
				chan_status_q[i] <= gpwa_pkg::ST_NORMAL;
			chan_inside_q <= '1;
			chan_outside_q <= '0;
			fault_q <= 1'b0;
			muted_q <= 1'b0;
		end else if (fire) begin
			chan_status_q <= status_n;
			chan_inside_q <= inside_n;
			chan_outside_q <= outside_n;
			fault_q <= fault_n;
			muted_q <= muted_n;
		end
	end

endmodule

FILE: src/gas_pressure_window_alarm.sv
// Gas pressure window alarm. Each input word is either a converter sample for one of five
// pressure channels (0..4) or the vacuum channel (5), or a mute press (command = 1). A sample
// is scaled to hundredths of bar or to mmHg, judged against the alarm window, and answered by
// one result word: the held low/normal/high status of that channel, the aggregate fault flag,
// the buzzer drive and three seven-segment codes of the shown value (tenths of bar for
// pressure, mmHg for vacuum, hundreds digit saturated at 9). Disabled channels read 3.50 bar
// or 500 mmHg. Mute presses and unknown channels return zero status and blank segments.
// The block takes one word per clock and keeps doing so as long as the result side drains;
// a taken word waits in the input register, then the two constant
// multiplies of the scaling (coefficient, then reciprocal division) each own a stage, and
// the window check, state update and digit decode fill the last one. Idle stages never hold
// back the input. Write configuration only while no word is in flight.
module gas_pressure_window_alarm #(
	parameter int NUM_CHANNELS = gpwa_pkg::NUM_CHANNELS_DEF,
	parameter int SAMPLE_BITS = gpwa_pkg::SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  gpwa_pkg::gpwa_in_t item,
	output logic result_valid,
	input  logic result_ready,
	output gpwa_pkg::gpwa_out_t result,
	input  logic cfg_we,
	input  logic [gpwa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [gpwa_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	// Configuration registers.
	logic [gpwa_pkg::ENABLED_BITS-1:0] enabled_channels_q;
	logic [gpwa_pkg::LIMIT_BITS-1:0] high_limit_q, low_limit_q;
	logic [gpwa_pkg::VAC_LIMIT_BITS-1:0] vacuum_limit_q;

	// Pipeline: s1 input word, s2 scaled quotient, s3 reading, s4 result word.
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	gpwa_pkg::gpwa_in_t item_s1;
	gpwa_pkg::gpwa_tag_t tag_s3;
	logic [gpwa_pkg::READ_BITS-1:0] reading_s3;
	gpwa_pkg::gpwa_out_t result_n, result_s4;
	logic fire_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_channels_q <= gpwa_pkg::ENABLED_RESET;
			high_limit_q <= gpwa_pkg::HIGH_LIMIT_RESET;
			low_limit_q <= gpwa_pkg::LOW_LIMIT_RESET;
			vacuum_limit_q <= gpwa_pkg::VAC_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				gpwa_pkg::CFG_ENABLED_CHANNELS:
					enabled_channels_q <= cfg_data[gpwa_pkg::ENABLED_BITS-1:0];
				gpwa_pkg::CFG_HIGH_LIMIT: high_limit_q <= cfg_data;
				gpwa_pkg::CFG_LOW_LIMIT: low_limit_q <= cfg_data;
				gpwa_pkg::CFG_VACUUM_LIMIT:
					vacuum_limit_q <= cfg_data[gpwa_pkg::VAC_LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or its word moves on; bubbles close up
	// even while the result word waits.
	assign rdy_s4 = !v_s4 || result_ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign item_ready = rdy_s1;

	// State advances only when a real word leaves the judge stage.
	assign fire_s3 = v_s3 && rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1)
				v_s1 <= item_valid;
			if (rdy_s2)
				v_s2 <= v_s1;
			if (rdy_s3)
				v_s3 <= v_s2;
			if (rdy_s4)
				v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1)
			item_s1 <= item;
		if (rdy_s4)
			result_s4 <= result_n;
	end

	gpwa_scale #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_scale (
		.clk(clk),
		.item_s1(item_s1),
		.enabled_channels(enabled_channels_q),
		.load_s2(rdy_s2),
		.load_s3(rdy_s3),
		.tag_s3(tag_s3),
		.reading_s3(reading_s3)
	);

	gpwa_judge #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_judge (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire_s3),
		.tag(tag_s3),
		.reading(reading_s3),
		.high_limit(high_limit_q),
		.low_limit(low_limit_q),
		.vacuum_limit(vacuum_limit_q),
		.result(result_n)
	);

	assign result_valid = v_s4;
	assign result = result_s4;

endmodule

FILE: bench/gas_pressure_window_alarm_tb.sv
module gas_pressure_window_alarm_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CH = gpwa_pkg::NUM_CHANNELS_DEF;
	localparam longint FULL_SCALE = longint'(1) << gpwa_pkg::SAMPLE_BITS_DEF;
	localparam int RAW_MAX = (1 << gpwa_pkg::RAW_BITS) - 1;

	// Command codes of an input word.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_MUTE = 1'b1;

	// Channel codes the scheme does not know; the block must ignore them.
	localparam logic [gpwa_pkg::CHANNEL_BITS-1:0] CH_NONE_A = 3'd6;
	localparam logic [gpwa_pkg::CHANNEL_BITS-1:0] CH_NONE_B = 3'd7;

	// Settling time once the pipeline is empty, before touching registers.
	localparam int DRAIN_CYCLES = 6;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES = 16;
	localparam int PHASE_WORDS = 95;
	// Receiver hold-off that backs the pipeline up into the input.
	localparam int HOLD_AFTER = 300;
	localparam int HOLD_CYCLES = 90;
	localparam int MAX_REPORTS = 10;

	typedef enum logic {
		ROW_WORD,
		ROW_REG
	} row_kind_t;

	// One line of the directed table: a register write or an input word, with an
	// optional hand-written expectation.
	typedef struct packed {
		row_kind_t kind;
		logic [gpwa_pkg::CFG_INDEX_BITS-1:0] idx;
		logic [gpwa_pkg::CFG_DATA_BITS-1:0] data;
		gpwa_pkg::gpwa_in_t word;
		logic typed;
		gpwa_pkg::gpwa_out_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	gpwa_pkg::gpwa_in_t item;
	logic result_valid;
	logic result_ready;
	gpwa_pkg::gpwa_out_t result;
	logic cfg_we;
	logic [gpwa_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [gpwa_pkg::CFG_DATA_BITS-1:0] cfg_data;

	// Mirror of the block: registers and per-channel alarm state.
	logic [gpwa_pkg::ENABLED_BITS-1:0] en_reg;
	logic [gpwa_pkg::LIMIT_BITS-1:0] high_reg;
	logic [gpwa_pkg::LIMIT_BITS-1:0] low_reg;
	logic [gpwa_pkg::VAC_LIMIT_BITS-1:0] vac_reg;
	gpwa_pkg::status_t held_status [NUM_CH];
	logic [NUM_CH-1:0] inside_set;
	logic [NUM_CH-1:0] outside_set;
	logic fault_set;
	logic mute_set;

	// Readouts predicted for accepted words, oldest first.
	gpwa_pkg::gpwa_out_t readout_queue[$];
	gpwa_pkg::gpwa_out_t head_readout;
	plan_row_t plan[$];

	int mismatches = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	bit no_gaps = 1'b0;

	// Sample values of the current phase: window edges and the vacuum edge.
	int lo_v;
	int hi_v;
	int vac_v;

	gas_pressure_window_alarm DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hundredths of bar from a raw reading; clamp below the zero offset.
	function automatic int press_hundredths(int v);
		longint a;
		longint b;
		a = 500 * longint'(v);
		b = 50 * FULL_SCALE;
		if (a <= b)
			return 0;
		return int'((a - b) * 1000 / (396 * FULL_SCALE));
	endfunction

	// mmHg of vacuum; the reading falls as the raw value rises.
	function automatic int vac_mmhg(int v);
		longint a;
		longint b;
		a = 46 * FULL_SCALE;
		b = 50 * longint'(v);
		if (a <= b)
			return 0;
		return int'((a - b) * 750062 / (38260 * FULL_SCALE));
	endfunction

	function automatic logic [gpwa_pkg::SEG_BITS-1:0] seg_code(int d);
		case (d)
			0: return 8'hfc;
			1: return 8'h60;
			2: return 8'hda;
			3: return 8'hf2;
			4: return 8'h66;
			5: return 8'hb6;
			6: return 8'hbe;
			7: return 8'he0;
			8: return 8'hff;
			default: return 8'hf6;
		endcase
	endfunction

	// p1 and p4 are always fitted; the rest come in with the channel count,
	// which clamps to 2..6.
	function automatic bit channel_fitted(int c);
		int n;
		n = en_reg;
		if (n < 2)
			n = 2;
		if (n > 6)
			n = 6;
		case (c)
			gpwa_pkg::CH_P1, gpwa_pkg::CH_P4: return 1'b1;
			gpwa_pkg::CH_VAC: return n >= 3;
			gpwa_pkg::CH_P2: return n >= 4;
			gpwa_pkg::CH_P3: return n >= 5;
			gpwa_pkg::CH_P5: return n >= 6;
			default: return 1'b0;
		endcase
	endfunction

	// Advance the mirror by one accepted word and return its readout.
	function automatic gpwa_pkg::gpwa_out_t judge_word(gpwa_pkg::gpwa_in_t w);
		gpwa_pkg::gpwa_out_t o;
		int c;
		int r;
		int shown;
		int h;
		int i;
		bit fitted;
		bit lo;
		bit hi;
		bit ins;
		o = '0;
		if (w.command == CMD_MUTE) begin
			mute_set = 1'b1;
		end else if (w.channel < gpwa_pkg::SCHEME_CHANNELS && w.channel < NUM_CH) begin
			c = w.channel;
			fitted = channel_fitted(c);
			if (c == gpwa_pkg::CH_VAC) begin
				r = fitted ? vac_mmhg(w.sample) : int'(gpwa_pkg::VAC_DISABLED);
				lo = r < vac_reg;
				hi = 1'b0;
				ins = r > vac_reg;
				shown = r;
			end else begin
				r = fitted ? press_hundredths(w.sample) : int'(gpwa_pkg::PRESS_DISABLED);
				lo = r < low_reg;
				hi = r > high_reg;
				ins = r > low_reg && r < high_reg;
				shown = r / 10;
			end
			// Low beats high; a reading on a limit keeps the old status.
			if (lo)
				held_status[c] = gpwa_pkg::ST_LOW;
			else if (hi)
				held_status[c] = gpwa_pkg::ST_HIGH;
			else if (ins)
				held_status[c] = gpwa_pkg::ST_NORMAL;
			inside_set[c] = ins;
			outside_set[c] = lo || hi;
			if (|outside_set)
				fault_set = 1'b1;
			if (&inside_set) begin
				fault_set = 1'b0;
				mute_set = 1'b0;
				for (i = 0; i < NUM_CH; i++)
					held_status[i] = gpwa_pkg::ST_NORMAL;
			end
			o.status = held_status[c];
			h = shown / 100;
			if (h > 9)
				h = 9;
			o.seg_ones = seg_code(shown % 10);
			o.seg_tens = seg_code((shown / 10) % 10);
			o.seg_hundreds = seg_code(h);
		end
		o.fault = fault_set;
		o.buzzer = fault_set && !mute_set;
		return o;
	endfunction

	// A raw value strictly inside the current window of the channel.
	function automatic int window_sample(int c);
		if (c == gpwa_pkg::CH_VAC)
			return $urandom_range(0, vac_v - 3);
		return $urandom_range(lo_v + 1, hi_v - 1);
	endfunction

	function automatic int corner_value(int top);
		case ($urandom_range(0, 2))
			0: return 0;
			1: return top;
			default: return $urandom_range(0, top);
		endcase
	endfunction

	task automatic plan_reg(input logic [gpwa_pkg::CFG_INDEX_BITS-1:0] idx, input int data);
		plan_row_t row;
		row = '0;
		row.kind = ROW_REG;
		row.idx = idx;
		row.data = gpwa_pkg::CFG_DATA_BITS'(data);
		plan.push_back(row);
	endtask

	task automatic plan_word(input logic cmd, input logic [gpwa_pkg::CHANNEL_BITS-1:0] ch,
			input int v);
		plan_row_t row;
		row = '0;
		row.kind = ROW_WORD;
		row.word.command = cmd;
		row.word.channel = ch;
		row.word.sample = gpwa_pkg::RAW_BITS'(v);
		plan.push_back(row);
	endtask

	task automatic plan_typed(input logic cmd, input logic [gpwa_pkg::CHANNEL_BITS-1:0] ch,
			input int v, input gpwa_pkg::status_t st, input logic f, input logic bz,
			input logic [gpwa_pkg::SEG_BITS-1:0] s1, input logic [gpwa_pkg::SEG_BITS-1:0] s10,
			input logic [gpwa_pkg::SEG_BITS-1:0] s100);
		plan_word(cmd, ch, v);
		plan[$].typed = 1'b1;
		plan[$].want = {st, f, bz, s1, s10, s100};
	endtask

	// Offer one word, hold it until taken, then predict and maybe leave a gap.
	task automatic send_word(input gpwa_pkg::gpwa_in_t w, input logic typed,
			input gpwa_pkg::gpwa_out_t want);
		gpwa_pkg::gpwa_out_t predicted;
		int pick;
		int gap;
		cfg_we = 1'b0;
		item = w;
		item_valid = 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		predicted = judge_word(w);
		readout_queue.push_back(typed ? want : predicted);
		pick = $urandom_range(0, 99);
		if (no_gaps || pick < 55)
			gap = 0;
		else if (pick < 88)
			gap = $urandom_range(1, 3);
		else if (pick < 97)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 40);
		@(negedge clk);
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [gpwa_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [gpwa_pkg::CFG_DATA_BITS-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		case (idx)
			gpwa_pkg::CFG_ENABLED_CHANNELS: en_reg = data[gpwa_pkg::ENABLED_BITS-1:0];
			gpwa_pkg::CFG_HIGH_LIMIT: high_reg = data[gpwa_pkg::LIMIT_BITS-1:0];
			gpwa_pkg::CFG_LOW_LIMIT: low_reg = data[gpwa_pkg::LIMIT_BITS-1:0];
			gpwa_pkg::CFG_VACUUM_LIMIT: vac_reg = data[gpwa_pkg::VAC_LIMIT_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Drop valid, let every readout come back, then let the pipe settle.
	task automatic wait_idle();
		item_valid = 1'b0;
		while (readout_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic check_field(input string fname, input logic [gpwa_pkg::SEG_BITS-1:0] want,
			input logic [gpwa_pkg::SEG_BITS-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, fname, want, got);
		end
	endtask

	// Receiver: random ready pattern with bursts, plus one long hold-off
	// once traffic is well under way so the block backs up into its input.
	initial begin
		int pick;
		int span;
		bit held;
		held = 1'b0;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				result_ready = 1'b0;
				span = HOLD_CYCLES;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					result_ready = 1'b1;
					span = $urandom_range(1, 6);
				end else if (pick < 80) begin
					result_ready = 1'b0;
					span = $urandom_range(1, 3);
				end else if (pick < 93) begin
					result_ready = 1'b1;
					span = $urandom_range(30, 60);
				end else begin
					result_ready = 1'b0;
					span = $urandom_range(8, 40);
				end
			end
			repeat (span) @(negedge clk);
		end
	end

	// Check each result word against the oldest prediction; the watchdog
	// ends the run if nothing moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (readout_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result word %h with nothing expected", $realtime, result);
				end else begin
					head_readout = readout_queue.pop_front();
					check_field("status", gpwa_pkg::SEG_BITS'(head_readout.status),
						gpwa_pkg::SEG_BITS'(result.status));
					check_field("fault", gpwa_pkg::SEG_BITS'(head_readout.fault),
						gpwa_pkg::SEG_BITS'(result.fault));
					check_field("buzzer", gpwa_pkg::SEG_BITS'(head_readout.buzzer),
						gpwa_pkg::SEG_BITS'(result.buzzer));
					check_field("seg_ones", head_readout.seg_ones, result.seg_ones);
					check_field("seg_tens", head_readout.seg_tens, result.seg_tens);
					check_field("seg_hundreds", head_readout.seg_hundreds, result.seg_hundreds);
					results_seen++;
				end
			end
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int p;
		int n;
		int pick;
		int q;
		int c;
		int v;
		int mode;
		int en_pick;
		int hl;
		int ll;
		int vl;
		gpwa_pkg::gpwa_in_t w;
		row_kind_t last_kind;

		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = gpwa_pkg::CFG_ENABLED_CHANNELS;
		cfg_data = '0;

		en_reg = gpwa_pkg::ENABLED_RESET;
		high_reg = gpwa_pkg::HIGH_LIMIT_RESET;
		low_reg = gpwa_pkg::LOW_LIMIT_RESET;
		vac_reg = gpwa_pkg::VAC_LIMIT_RESET;
		for (c = 0; c < NUM_CH; c++)
			held_status[c] = gpwa_pkg::ST_NORMAL;
		inside_set = '1;
		outside_set = '0;
		fault_set = 1'b0;
		mute_set = 1'b0;

		// Directed table. Fresh from reset: mute, then unknown channels, then
		// the raw extremes on p1 and vacuum under the reset window.
		plan_typed(CMD_MUTE, gpwa_pkg::CH_P1, 0, gpwa_pkg::ST_NORMAL, 1'b0, 1'b0,
			8'h00, 8'h00, 8'h00);
		plan_typed(CMD_SAMPLE, CH_NONE_A, RAW_MAX, gpwa_pkg::ST_NORMAL, 1'b0, 1'b0,
			8'h00, 8'h00, 8'h00);
		plan_typed(CMD_SAMPLE, CH_NONE_B, 0, gpwa_pkg::ST_NORMAL, 1'b0, 1'b0,
			8'h00, 8'h00, 8'h00);
		plan_typed(CMD_SAMPLE, gpwa_pkg::CH_P1, 0, gpwa_pkg::ST_LOW, 1'b1, 1'b0,
			8'hfc, 8'hfc, 8'hfc);
		plan_typed(CMD_SAMPLE, gpwa_pkg::CH_P1, RAW_MAX, gpwa_pkg::ST_HIGH, 1'b1, 1'b0,
			8'hf2, 8'h60, 8'h60);
		plan_typed(CMD_SAMPLE, gpwa_pkg::CH_VAC, 0, gpwa_pkg::ST_NORMAL, 1'b1, 1'b0,
			8'h60, 8'hfc, 8'hf6);
		plan_typed(CMD_SAMPLE, gpwa_pkg::CH_VAC, RAW_MAX, gpwa_pkg::ST_LOW, 1'b1, 1'b0,
			8'hfc, 8'hfc, 8'hfc);
		// Bring every channel inside: fault and mute clear on the last one.
		for (c = gpwa_pkg::CH_P1; c <= gpwa_pkg::CH_VAC; c++)
			plan_word(CMD_SAMPLE, gpwa_pkg::CHANNEL_BITS'(c), 500);
		// Put limits exactly on reachable readings so boundary samples hold status.
		plan_reg(gpwa_pkg::CFG_LOW_LIMIT, press_hundredths(300));
		plan_reg(gpwa_pkg::CFG_HIGH_LIMIT, press_hundredths(700));
		plan_word(CMD_SAMPLE, gpwa_pkg::CH_P4, 700);
		plan_word(CMD_SAMPLE, gpwa_pkg::CH_P4, 0);
		plan_word(CMD_SAMPLE, gpwa_pkg::CH_P4, 300);
		plan_word(CMD_SAMPLE, gpwa_pkg::CH_P4, RAW_MAX);
		plan_reg(gpwa_pkg::CFG_VACUUM_LIMIT, vac_mmhg(600));
		plan_word(CMD_SAMPLE, gpwa_pkg::CH_VAC, 600);
		plan_word(CMD_MUTE, gpwa_pkg::CH_P1, 0);
		// Channel count below range acts as two: p2, p5 and vacuum read fixed.
		plan_reg(gpwa_pkg::CFG_ENABLED_CHANNELS, 0);
		plan_word(CMD_SAMPLE, gpwa_pkg::CH_P2, RAW_MAX);
		plan_word(CMD_SAMPLE, gpwa_pkg::CH_VAC, 0);
		plan_word(CMD_SAMPLE, gpwa_pkg::CH_P5, 0);
		// Count above range, and an inverted window where low must win.
		plan_reg(gpwa_pkg::CFG_ENABLED_CHANNELS, 7);
		plan_reg(gpwa_pkg::CFG_LOW_LIMIT, 800);
		plan_reg(gpwa_pkg::CFG_HIGH_LIMIT, 100);
		plan_word(CMD_SAMPLE, gpwa_pkg::CH_P1, 500);
		// Register extremes.
		plan_reg(gpwa_pkg::CFG_HIGH_LIMIT, 0);
		plan_reg(gpwa_pkg::CFG_LOW_LIMIT, (1 << gpwa_pkg::LIMIT_BITS) - 1);
		plan_reg(gpwa_pkg::CFG_VACUUM_LIMIT, (1 << gpwa_pkg::VAC_LIMIT_BITS) - 1);
		plan_word(CMD_SAMPLE, gpwa_pkg::CH_P3, 700);
		plan_word(CMD_SAMPLE, gpwa_pkg::CH_VAC, 0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the table; settle the pipe before the first write of a group.
		last_kind = ROW_WORD;
		foreach (plan[k]) begin
			if (plan[k].kind == ROW_REG) begin
				if (last_kind == ROW_WORD)
					wait_idle();
				write_reg(plan[k].idx, plan[k].data);
			end else begin
				send_word(plan[k].word, plan[k].typed, plan[k].want);
			end
			last_kind = plan[k].kind;
		end

		// Random phases: a fresh register set, then mostly well-formed traffic
		// around the window edges, with sweeps that try to pull every channel inside.
		for (p = 0; p < PHASES; p++) begin
			wait_idle();
			lo_v = $urandom_range(110, 480);
			hi_v = $urandom_range(lo_v + 6, 1000);
			vac_v = $urandom_range(100, 900);
			mode = $urandom_range(0, 5);
			en_pick = $urandom_range(0, 7);
			if (mode <= 3) begin
				hl = press_hundredths(hi_v);
				ll = press_hundredths(lo_v);
				vl = vac_mmhg(vac_v);
			end else if (mode == 4) begin
				hl = corner_value((1 << gpwa_pkg::LIMIT_BITS) - 1);
				ll = corner_value((1 << gpwa_pkg::LIMIT_BITS) - 1);
				vl = corner_value((1 << gpwa_pkg::VAC_LIMIT_BITS) - 1);
			end else begin
				hl = press_hundredths(lo_v);
				ll = press_hundredths(hi_v);
				vl = vac_mmhg(vac_v);
			end
			// Toggle unused upper data bits; the block keeps only its field.
			write_reg(gpwa_pkg::CFG_ENABLED_CHANNELS, gpwa_pkg::CFG_DATA_BITS'(
				($urandom_range(0, 255) << gpwa_pkg::ENABLED_BITS) | en_pick));
			write_reg(gpwa_pkg::CFG_HIGH_LIMIT, gpwa_pkg::CFG_DATA_BITS'(hl));
			write_reg(gpwa_pkg::CFG_LOW_LIMIT, gpwa_pkg::CFG_DATA_BITS'(ll));
			write_reg(gpwa_pkg::CFG_VACUUM_LIMIT, gpwa_pkg::CFG_DATA_BITS'(
				($urandom_range(0, 1) << gpwa_pkg::VAC_LIMIT_BITS) | vl));
			no_gaps = ($urandom_range(0, 3) == 0);

			n = 0;
			while (n < PHASE_WORDS) begin
				pick = $urandom_range(0, 99);
				w.command = CMD_SAMPLE;
				w.channel = gpwa_pkg::CHANNEL_BITS'(
					$urandom_range(gpwa_pkg::CH_P1, gpwa_pkg::CH_VAC));
				w.sample = gpwa_pkg::RAW_BITS'($urandom_range(0, RAW_MAX));
				if (pick < 4) begin
					w.command = CMD_MUTE;
					w.channel = gpwa_pkg::CHANNEL_BITS'(
						$urandom_range(0, (1 << gpwa_pkg::CHANNEL_BITS) - 1));
					send_word(w, 1'b0, '0);
					n++;
				end else if (pick < 7) begin
					w.channel = gpwa_pkg::CHANNEL_BITS'($urandom_range(CH_NONE_A, CH_NONE_B));
					send_word(w, 1'b0, '0);
					n++;
				end else if (pick < 15) begin
					for (c = gpwa_pkg::CH_P1; c <= gpwa_pkg::CH_VAC; c++) begin
						w.channel = gpwa_pkg::CHANNEL_BITS'(c);
						w.sample = gpwa_pkg::RAW_BITS'(window_sample(c));
						send_word(w, 1'b0, '0);
					end
					n += NUM_CH;
				end else begin
					c = w.channel;
					q = $urandom_range(0, 9);
					if (q < 4)
						v = w.sample;
					else if (q < 6)
						v = (c == gpwa_pkg::CH_VAC) ? vac_v
							: ($urandom_range(0, 1) ? lo_v : hi_v);
					else
						v = window_sample(c);
					w.sample = gpwa_pkg::RAW_BITS'(v);
					send_word(w, 1'b0, '0);
					n++;
				end
			end
		end

		// Drain, give stray words a chance to show up, then judge.
		item_valid = 1'b0;
		cfg_we = 1'b0;
		while (readout_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && readout_queue.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
